FILE: rtl/dwpf_pkg.sv
// Shared types, constants and helpers for the display window pixel framer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dwpf_pkg;

  localparam int COORD_BITS = 10;
  localparam int COUNT_W    = 21;
  localparam int BYTE_W     = 8;
  localparam int RED_W      = 5;
  localparam int GHALF_W    = 3;
  localparam int GREEN_W    = 2 * GHALF_W;
  localparam int BLUE_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

  // input tdata layout, lowest bit first
  localparam int OFF_X_START = 0;
  localparam int OFF_Y_START = OFF_X_START + COORD_BITS;
  localparam int OFF_X_END   = OFF_Y_START + COORD_BITS;
  localparam int OFF_Y_END   = OFF_X_END + COORD_BITS;
  localparam int OFF_RED     = OFF_Y_END + COORD_BITS;
  localparam int OFF_GHIGH   = OFF_RED + RED_W;
  localparam int OFF_GLOW    = OFF_GHIGH + GHALF_W;
  localparam int OFF_BLUE    = OFF_GLOW + GHALF_W;
  localparam int IN_BITS     = OFF_BLUE + BLUE_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W   = 1;
  localparam int OUT_USER_W  = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte positions within one item's run
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_COL_CMD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_XS_HI   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XS_LO   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_XE_HI   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_XE_LO   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_PG_CMD  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_YS_HI   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_YS_LO   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_YE_HI   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_YE_LO   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_WR_CMD  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_PIX_R   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PIX_G   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PIX_B   = 4'd2;

  typedef struct packed {
    logic                   is_pixel;
    logic [COORD_BITS-1:0]  x_start;
    logic [COORD_BITS-1:0]  x_end;
    logic [COORD_BITS-1:0]  y_start;
    logic [COORD_BITS-1:0]  y_end;
    logic [RED_W-1:0]       red;
    logic [GREEN_W-1:0]     green;
    logic [BLUE_W-1:0]      blue;
    logic [COUNT_W-1:0]     area;
  } dwpf_item_t;

  function automatic logic [BYTE_W-1:0] coord_hi(input logic [COORD_BITS-1:0] c);
    logic [15:0] w;
    w = 16'(c);
    return w[15:8];
  endfunction

  function automatic logic [BYTE_W-1:0] coord_lo(input logic [COORD_BITS-1:0] c);
    logic [15:0] w;
    w = 16'(c);
    return w[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dwpf_front.sv
// Front end: unpacks and classifies input requests, computes the window area.
// Depends on dwpf_pkg.
`default_nettype none

module dwpf_front (
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dwpf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [dwpf_pkg::IN_USER_W-1:0]   in_tuser,
  input  wire logic                             q_full,
  output logic                                  push,
  output dwpf_pkg::dwpf_item_t                  push_item
);

  localparam int CB     = dwpf_pkg::COORD_BITS;
  localparam int SPAN_W = CB + 1;
  localparam int PROD_W = 2 * SPAN_W;
  localparam int CMP_W  = (PROD_W > dwpf_pkg::COUNT_W) ? PROD_W : dwpf_pkg::COUNT_W;

  logic [CB-1:0]     xs, ys, xe, ye;
  logic [SPAN_W-1:0] x_span, y_span;
  logic [PROD_W-1:0] prod;
  logic              inverted;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  assign xs = in_tdata[dwpf_pkg::OFF_X_START +: CB];
  assign ys = in_tdata[dwpf_pkg::OFF_Y_START +: CB];
  assign xe = in_tdata[dwpf_pkg::OFF_X_END +: CB];
  assign ye = in_tdata[dwpf_pkg::OFF_Y_END +: CB];

  assign inverted = (xe < xs) || (ye < ys);
  assign x_span   = SPAN_W'({1'b0, xe} - {1'b0, xs} + SPAN_W'(1));
  assign y_span   = SPAN_W'({1'b0, ye} - {1'b0, ys} + SPAN_W'(1));
  assign prod     = PROD_W'(x_span) * PROD_W'(y_span);

  always_comb begin
    push_item          = '0;
    push_item.is_pixel = in_tuser[0];
    push_item.x_start  = xs;
    push_item.x_end    = xe;
    push_item.y_start  = ys;
    push_item.y_end    = ye;
    push_item.red      = in_tdata[dwpf_pkg::OFF_RED +: dwpf_pkg::RED_W];
    push_item.green    = {in_tdata[dwpf_pkg::OFF_GHIGH +: dwpf_pkg::GHALF_W],
                          in_tdata[dwpf_pkg::OFF_GLOW +: dwpf_pkg::GHALF_W]};
    push_item.blue     = in_tdata[dwpf_pkg::OFF_BLUE +: dwpf_pkg::BLUE_W];
    if (inverted) begin
      push_item.area = '0;
    end else if (CMP_W'(prod) > CMP_W'(dwpf_pkg::COUNT_MAX)) begin
      push_item.area = dwpf_pkg::COUNT_MAX;
    end else begin
      push_item.area = dwpf_pkg::COUNT_W'(prod);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dwpf_queue.sv
// Short request queue between front end and byte sequencer.
// Depends on dwpf_pkg.
`default_nettype none

module dwpf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire dwpf_pkg::dwpf_item_t  push_item,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       q_valid,
  output dwpf_pkg::dwpf_item_t       q_item
);

  localparam int D = dwpf_pkg::QUEUE_DEPTH;

  dwpf_pkg::dwpf_item_t              mem_r [D];
  logic [dwpf_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dwpf_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dwpf_pkg::QCNT_W-1:0]       count_r, count_nxt;

  function automatic logic [dwpf_pkg::QPTR_W-1:0] ptr_inc(
      input logic [dwpf_pkg::QPTR_W-1:0] p);
    return (p == dwpf_pkg::QPTR_W'(D - 1)) ? '0 : dwpf_pkg::QPTR_W'(p + 1'b1);
  endfunction

  assign full    = (count_r == dwpf_pkg::QCNT_W'(D));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dwpf_back.sv
// Back end: steps through the bytes of each queued request, keeps the pixel
// count and drives the registered output stream. Depends on dwpf_pkg.
`default_nettype none

module dwpf_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire dwpf_pkg::dwpf_item_t              q_item,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [dwpf_pkg::BYTE_W-1:0]            out_tdata,
  output logic [dwpf_pkg::OUT_USER_W-1:0]        out_tuser,
  output logic                                   out_tlast
);

  dwpf_pkg::dwpf_item_t                  cur_r, cur_nxt;
  logic                                  busy_r, busy_nxt;
  logic [dwpf_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic [dwpf_pkg::COUNT_W-1:0]          pixels_left_r, pixels_left_nxt;
  logic                                  out_tvalid_r, out_tvalid_nxt;
  logic [dwpf_pkg::BYTE_W-1:0]           out_tdata_r, out_tdata_nxt;
  logic [dwpf_pkg::OUT_USER_W-1:0]       out_tuser_r, out_tuser_nxt;
  logic                                  out_tlast_r, out_tlast_nxt;

  logic                                  out_adv, emit, at_last, item_end, done;
  logic                                  is_data;
  logic [dwpf_pkg::BYTE_W-1:0]           byte_val;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign out_adv  = !out_tvalid_r || out_tready;
  assign emit     = busy_r && out_adv;
  assign at_last  = cur_r.is_pixel ? (step_r == dwpf_pkg::STEP_PIX_B)
                                   : (step_r == dwpf_pkg::STEP_WR_CMD);
  assign item_end = emit && at_last;
  assign q_pop    = q_valid && (!busy_r || item_end);
  assign done     = cur_r.is_pixel && at_last &&
                    (pixels_left_r == dwpf_pkg::COUNT_W'(1));

  always_comb begin
    byte_val = '0;
    is_data  = 1'b1;
    if (cur_r.is_pixel) begin
      unique case (step_r)
        dwpf_pkg::STEP_PIX_R: byte_val = {cur_r.red, 3'b000};
        dwpf_pkg::STEP_PIX_G: byte_val = {cur_r.green, 2'b00};
        dwpf_pkg::STEP_PIX_B: byte_val = {cur_r.blue, 3'b000};
        default:              byte_val = '0;
      endcase
    end else begin
      unique case (step_r)
        dwpf_pkg::STEP_COL_CMD: begin
          byte_val = dwpf_pkg::CMD_COLUMN;
          is_data  = 1'b0;
        end
        dwpf_pkg::STEP_XS_HI:   byte_val = dwpf_pkg::coord_hi(cur_r.x_start);
        dwpf_pkg::STEP_XS_LO:   byte_val = dwpf_pkg::coord_lo(cur_r.x_start);
        dwpf_pkg::STEP_XE_HI:   byte_val = dwpf_pkg::coord_hi(cur_r.x_end);
        dwpf_pkg::STEP_XE_LO:   byte_val = dwpf_pkg::coord_lo(cur_r.x_end);
        dwpf_pkg::STEP_PG_CMD: begin
          byte_val = dwpf_pkg::CMD_PAGE;
          is_data  = 1'b0;
        end
        dwpf_pkg::STEP_YS_HI:   byte_val = dwpf_pkg::coord_hi(cur_r.y_start);
        dwpf_pkg::STEP_YS_LO:   byte_val = dwpf_pkg::coord_lo(cur_r.y_start);
        dwpf_pkg::STEP_YE_HI:   byte_val = dwpf_pkg::coord_hi(cur_r.y_end);
        dwpf_pkg::STEP_YE_LO:   byte_val = dwpf_pkg::coord_lo(cur_r.y_end);
        dwpf_pkg::STEP_WR_CMD: begin
          byte_val = dwpf_pkg::CMD_WRITE;
          is_data  = 1'b0;
        end
        default:                byte_val = '0;
      endcase
    end
  end

  always_comb begin
    cur_nxt         = q_pop ? q_item : cur_r;
    busy_nxt        = busy_r;
    step_nxt        = step_r;
    pixels_left_nxt = pixels_left_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;
    out_tlast_nxt   = out_tlast_r;

    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (item_end) begin
      busy_nxt = 1'b0;
      step_nxt = '0;
    end else if (emit) begin
      step_nxt = step_r + 1'b1;
    end

    // update count on the final byte of each request
    if (item_end) begin
      if (!cur_r.is_pixel) begin
        pixels_left_nxt = cur_r.area;
      end else if (pixels_left_r != '0) begin
        pixels_left_nxt = pixels_left_r - 1'b1;
      end
    end

    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = byte_val;
      out_tuser_nxt  = {done, is_data};
      out_tlast_nxt  = at_last;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      step_r        <= '0;
      pixels_left_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      busy_r        <= busy_nxt;
      step_r        <= step_nxt;
      pixels_left_r <= pixels_left_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/display_window_pixel_framer_core.sv
// Display write framer: turns set-window and pixel requests into a tagged byte
// stream. A set-window request yields eleven bytes (column command, start and
// end column high/low, page command, start and end row high/low, memory-write
// command) and loads the pixel count with the window area, or zero for an
// inverted window. A pixel request yields three data bytes of 5-6-5 color; the
// last byte of the window's final pixel carries window_complete. The output
// moves one byte per cycle while the receiver accepts every byte; the byte
// sequencer in the back end steps through each request's bytes, and a
// two-entry queue lets requests be accepted while earlier ones are still being
// sent. A request passes through the queue, the current-request register and
// the output register. Depends on dwpf_pkg, dwpf_front, dwpf_queue, dwpf_back.
`default_nettype none

module display_window_pixel_framer_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // x_start, y_start, x_end, y_end, red, green_high, green_low, blue
  input  wire logic [dwpf_pkg::IN_DATA_W-1:0]    in_tdata,
  // command (0 set window, 1 pixel)
  input  wire logic [dwpf_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_byte
  output logic [dwpf_pkg::BYTE_W-1:0]            out_tdata,
  // is_data, window_complete
  output logic [dwpf_pkg::OUT_USER_W-1:0]        out_tuser,
  output logic                                   out_tlast
);

  logic                  q_full;
  logic                  push;
  dwpf_pkg::dwpf_item_t  push_item;
  logic                  q_pop;
  logic                  q_valid;
  dwpf_pkg::dwpf_item_t  q_item;

  dwpf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  dwpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  dwpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: dv/display_window_pixel_framer_core_tb.sv
// Self-checking testbench for display_window_pixel_framer_core: set-window and
// pixel requests go in, the tagged byte stream is predicted and checked per byte.
// Depends on dwpf_pkg and the core RTL only.
module display_window_pixel_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpf_pkg::*;

  localparam int NUM_REQUESTS = 280;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOW_ERRORS  = 10;

  typedef struct {
    logic                  is_pixel;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    logic [RED_W-1:0]      red;
    logic [GHALF_W-1:0]    g_hi;
    logic [GHALF_W-1:0]    g_lo;
    logic [BLUE_W-1:0]     blue;
    bit                    hold_for_drain;
    int                    phase;
  } request_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              is_data;
    logic              last;
    logic              done;
  } wire_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  request_t     request_queue[$];
  request_t     shown_request;
  wire_byte_t   expected_bytes[$];
  logic [COUNT_W-1:0] pixels_left = '0;

  int tx_idle = 21;
  int rx_idle = 63;
  int queued = 0;
  int errors = 0;
  int windows_sent = 0;
  int pixels_sent = 0;
  int bytes_checked = 0;
  int windows_closed = 0;
  int cycles = 0;

  display_window_pixel_framer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= SHOW_ERRORS) $display("%s", msg);
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] data, logic is_data, logic last,
                                    logic done);
    wire_byte_t b;
    b.data    = data;
    b.is_data = is_data;
    b.last    = last;
    b.done    = done;
    expected_bytes.push_back(b);
  endfunction

  function automatic void push_coord(logic [COORD_BITS-1:0] c);
    logic [15:0] wide;
    wide = 16'(c);
    push_byte(wide[15:8], 1'b1, 1'b0, 1'b0);
    push_byte(wide[7:0], 1'b1, 1'b0, 1'b0);
  endfunction

  function automatic void frame_request(request_t r);
    longint unsigned area;
    logic [GREEN_W-1:0] green;
    logic done;
    if (!r.is_pixel) begin
      push_byte(CMD_COLUMN, 1'b0, 1'b0, 1'b0);
      push_coord(r.xs);
      push_coord(r.xe);
      push_byte(CMD_PAGE, 1'b0, 1'b0, 1'b0);
      push_coord(r.ys);
      push_coord(r.ye);
      push_byte(CMD_WRITE, 1'b0, 1'b1, 1'b0);
      if (r.xe < r.xs || r.ye < r.ys) begin
        pixels_left = '0;
      end else begin
        area = (longint'(r.xe) - longint'(r.xs) + 1) * (longint'(r.ye) - longint'(r.ys) + 1);
        pixels_left = (area > longint'(COUNT_MAX)) ? COUNT_MAX : area[COUNT_W-1:0];
      end
    end else begin
      green = {r.g_hi, r.g_lo};
      done = (pixels_left == 1);
      if (pixels_left != 0) pixels_left = pixels_left - 1'b1;
      push_byte({r.red, 3'b000}, 1'b1, 1'b0, 1'b0);
      push_byte({green, 2'b00}, 1'b1, 1'b0, 1'b0);
      push_byte({r.blue, 3'b000}, 1'b1, 1'b1, done);
    end
  endfunction

  function automatic void queue_request(request_t r);
    r.phase = (queued * 3) / NUM_REQUESTS;
    if (r.phase > 2) r.phase = 2;
    request_queue.push_back(r);
    queued++;
  endfunction

  function automatic void queue_window(int xs, int ys, int xe, int ye, bit drain);
    request_t r;
    r = '{default: '0};
    r.xs = COORD_BITS'(xs);
    r.ys = COORD_BITS'(ys);
    r.xe = COORD_BITS'(xe);
    r.ye = COORD_BITS'(ye);
    r.hold_for_drain = drain;
    queue_request(r);
  endfunction

  function automatic void queue_pixel(int red, int g_hi, int g_lo, int blue);
    request_t r;
    r = '{default: '0};
    r.is_pixel = 1'b1;
    r.red  = RED_W'(red);
    r.g_hi = GHALF_W'(g_hi);
    r.g_lo = GHALF_W'(g_lo);
    r.blue = BLUE_W'(blue);
    queue_request(r);
  endfunction

  function automatic void queue_random_pixel();
    queue_pixel($urandom_range(31), $urandom_range(7), $urandom_range(7), $urandom_range(31));
  endfunction

  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     show;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_request(shown_request);
        if (shown_request.is_pixel) pixels_sent++;
        else windows_sent++;
      end
      if (!in_tvalid || in_tready) begin
        show = 1'b0;
        if (request_queue.size() > 0) begin
          case (request_queue[0].phase)
            0: begin
              tx_idle = 21;
              rx_idle = 63;
            end
            1: begin
              tx_idle = 63;
              rx_idle = 21;
            end
            default: begin
              tx_idle = 0;
              rx_idle = 0;
            end
          endcase
          if (!(request_queue[0].hold_for_drain && expected_bytes.size() > 0) &&
              $urandom_range(99) >= tx_idle) begin
            show = 1'b1;
          end
        end
        if (show) begin
          nxt = request_queue.pop_front();
          shown_request = nxt;
          in_tdata <= IN_DATA_W'({nxt.blue, nxt.g_lo, nxt.g_hi, nxt.red,
                                  nxt.ye, nxt.xe, nxt.ys, nxt.xs});
          in_tuser <= nxt.is_pixel;
        end
        in_tvalid <= show;
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    wire_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %02h dc %b last %b done %b",
                               out_tdata, out_tuser[0], out_tlast, out_tuser[1]));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.done) windows_closed++;
          if (out_tdata !== want.data || out_tuser[0] !== want.is_data ||
              out_tlast !== want.last || out_tuser[1] !== want.done) begin
            note_error($sformatf(
              "byte %0d: expected %02h dc %b last %b done %b, got %02h dc %b last %b done %b",
              bytes_checked, want.data, want.is_data, want.last, want.done,
              out_tdata, out_tuser[0], out_tlast, out_tuser[1]));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAIL display_window_pixel_framer_core");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int w;
    int h;
    int xs;
    int ys;
    int n;
    int k;
    queue_pixel(31, 7, 7, 31);
    queue_window(0, 0, 0, 0, 1'b0);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(21, 5, 2, 10);
    queue_window(0, 0, 1023, 1023, 1'b0);
    queue_pixel(10, 2, 5, 21);
    queue_pixel(31, 0, 7, 0);
    queue_window(1023, 1023, 1023, 1023, 1'b0);
    queue_pixel(31, 7, 7, 31);
    queue_window(5, 2, 4, 9, 1'b0);
    queue_pixel(1, 4, 1, 16);
    queue_window(2, 9, 8, 3, 1'b0);
    queue_pixel(16, 1, 4, 1);
    queue_window(1, 2, 2, 4, 1'b1);
    for (int i = 0; i < 7; i++) queue_random_pixel();
    queue_window(768, 513, 1023, 514, 1'b0);
    queue_pixel(0, 7, 0, 31);

    while (queued < NUM_REQUESTS) begin
      pick = $urandom_range(9);
      if (pick <= 6 || pick == 9) begin
        w  = $urandom_range(3);
        h  = $urandom_range(3);
        xs = $urandom_range(1023 - w);
        ys = $urandom_range(1023 - h);
        queue_window(xs, ys, xs + w, ys + h, pick == 9);
        n = (w + 1) * (h + 1);
        k = $urandom_range(3);
        if (k == 0) n = n - 1;
        else if (k == 3) n = n + 1;
        for (int i = 0; i < n; i++) queue_random_pixel();
      end else if (pick == 7) begin
        queue_window($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(1023), 1'b0);
        n = $urandom_range(2);
        for (int i = 0; i < n; i++) queue_random_pixel();
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) queue_random_pixel();
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || in_tvalid || expected_bytes.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      note_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
    end
    $display("Sent %0d window and %0d pixel requests; checked %0d bytes, %0d windows closed.",
             windows_sent, pixels_sent, bytes_checked, windows_closed);
    $display("Mismatches: %0d over %0d cycles.", errors, cycles);
    if (errors == 0) begin
      $display("PASS display_window_pixel_framer_core");
    end else begin
      $display("FAIL display_window_pixel_framer_core");
    end
    $finish;
  end

endmodule
